FILE: hw/rtl/coap_pkg.sv
// Shared types, phase codes and helpers for the CoAP message parser.
package coap_pkg;

    // One input beat: a datagram byte and its end mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_datagram;
    } t_coap_in;

    // One result beat: byte class plus decoded message state.
    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  byte_value;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [1:0]  protocol_version;
        logic [1:0]  message_type;
        logic [3:0]  token_length;
        logic [7:0]  code_value;
        logic [15:0] message_id;
        logic [1:0]  error_code;
        logic        message_done;
    } t_coap_out;

    // Parse phases.
    localparam logic [3:0] PH_H0       = 4'd0;
    localparam logic [3:0] PH_H1       = 4'd1;
    localparam logic [3:0] PH_H2       = 4'd2;
    localparam logic [3:0] PH_H3       = 4'd3;
    localparam logic [3:0] PH_TOKEN    = 4'd4;
    localparam logic [3:0] PH_OPT_HEAD = 4'd5;
    localparam logic [3:0] PH_D8       = 4'd6;
    localparam logic [3:0] PH_D16_HI   = 4'd7;
    localparam logic [3:0] PH_D16_LO   = 4'd8;
    localparam logic [3:0] PH_L8       = 4'd9;
    localparam logic [3:0] PH_L16_HI   = 4'd10;
    localparam logic [3:0] PH_L16_LO   = 4'd11;
    localparam logic [3:0] PH_DATA     = 4'd12;
    localparam logic [3:0] PH_PAYLOAD  = 4'd13;
    localparam logic [3:0] PH_IGNORE   = 4'd14;

    // Byte classes.
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_TOKEN    = 3'd1;
    localparam logic [2:0] KIND_OPT_HEAD = 3'd2;
    localparam logic [2:0] KIND_OPT_EXT  = 3'd3;
    localparam logic [2:0] KIND_OPT_DATA = 3'd4;
    localparam logic [2:0] KIND_MARKER   = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd6;
    localparam logic [2:0] KIND_IGNORE   = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_TOKEN = 2'd2;
    localparam logic [1:0] ERR_TRUNC = 2'd3;

    // Protocol constants.
    localparam logic [3:0]  TOKEN_MAX   = 4'd8;
    localparam logic [3:0]  NIB_EXT8    = 4'd13;
    localparam logic [3:0]  NIB_EXT16   = 4'd14;
    localparam logic [7:0]  MARKER_BYTE = 8'hff;
    localparam logic [16:0] EXT8_BIAS   = 17'd13;
    localparam logic [16:0] EXT16_BIAS  = 17'd269;

    // Clamp a 17-bit sum to 16 bits.
    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hffff : v[15:0];
    endfunction

endpackage

FILE: hw/rtl/coap_parse_core.sv
// Parse state registers and the per-byte next-state and result logic.
module coap_parse_core
    import coap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_coap_in  i_item,
    output t_coap_out o_result
);

    logic [3:0]  r_phase,  n_phase;
    logic [15:0] r_fc,     n_fc;
    logic [3:0]  r_vt,     n_vt;
    logic [3:0]  r_tl,     n_tl;
    logic [7:0]  r_code,   n_code;
    logic [15:0] r_msg_id, n_msg_id;
    logic [15:0] r_run,    n_run;
    logic [15:0] r_plen,   n_plen;
    logic [3:0]  r_ext,    n_ext;
    logic [1:0]  r_err,    n_err;

    logic [7:0]  b;
    logic [2:0]  kind;
    logic        do_delta;
    logic        do_len;
    logic [16:0] delta_sum;
    logic [15:0] delta_val;
    logic [15:0] fc_dec;

    assign b      = i_item.in_byte;
    assign fc_dec = (r_fc == 16'd0) ? 16'd0 : r_fc - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_fc      = r_fc;
        n_vt      = r_vt;
        n_tl      = r_tl;
        n_code    = r_code;
        n_msg_id  = r_msg_id;
        n_run     = r_run;
        n_plen    = r_plen;
        n_ext     = r_ext;
        n_err     = r_err;
        kind      = KIND_IGNORE;
        do_delta  = 1'b0;
        do_len    = 1'b0;
        delta_sum = 17'd0;
        delta_val = 16'd0;

        case (r_phase)
            PH_H0: begin
                kind = KIND_HEADER;
                n_vt = b[7:4];
                n_tl = b[3:0];
                if (b[3:0] > TOKEN_MAX) begin
                    n_err   = ERR_TOKEN;
                    n_phase = PH_IGNORE;
                end else begin
                    n_phase = PH_H1;
                end
            end
            PH_H1: begin
                kind    = KIND_HEADER;
                n_code  = b;
                n_phase = PH_H2;
            end
            PH_H2: begin
                kind     = KIND_HEADER;
                n_msg_id = {b, 8'h00};
                n_phase  = PH_H3;
            end
            PH_H3: begin
                kind     = KIND_HEADER;
                n_msg_id = {r_msg_id[15:8], b};
                if (r_tl != 4'd0) begin
                    n_fc    = {12'd0, r_tl};
                    n_phase = PH_TOKEN;
                end else begin
                    n_phase = PH_OPT_HEAD;
                end
            end
            PH_TOKEN: begin
                kind = KIND_TOKEN;
                n_fc = fc_dec;
                if (fc_dec == 16'd0) begin
                    n_phase = PH_OPT_HEAD;
                end
            end
            PH_OPT_HEAD: begin
                if (b == MARKER_BYTE) begin
                    kind    = KIND_MARKER;
                    n_phase = PH_PAYLOAD;
                end else begin
                    kind   = KIND_OPT_HEAD;
                    n_ext  = b[3:0];
                    n_plen = (b[3:0] < NIB_EXT8) ? {12'd0, b[3:0]} : 16'd0;
                    if (b[7:4] == NIB_EXT8) begin
                        n_phase = PH_D8;
                    end else if (b[7:4] == NIB_EXT16) begin
                        n_phase = PH_D16_HI;
                    end else begin
                        do_delta  = 1'b1;
                        delta_sum = {13'd0, b[7:4]};
                    end
                end
            end
            PH_D8: begin
                kind      = KIND_OPT_EXT;
                do_delta  = 1'b1;
                delta_sum = {9'd0, b} + EXT8_BIAS;
            end
            PH_D16_HI: begin
                kind    = KIND_OPT_EXT;
                n_fc    = {8'd0, b};
                n_phase = PH_D16_LO;
            end
            PH_D16_LO: begin
                kind      = KIND_OPT_EXT;
                do_delta  = 1'b1;
                delta_sum = {1'b0, r_fc[7:0], b} + EXT16_BIAS;
            end
            PH_L8: begin
                kind   = KIND_OPT_EXT;
                n_plen = {8'd0, b} + EXT8_BIAS[15:0];
                do_len = 1'b1;
            end
            PH_L16_HI: begin
                kind    = KIND_OPT_EXT;
                n_fc    = {8'd0, b};
                n_phase = PH_L16_LO;
            end
            PH_L16_LO: begin
                kind   = KIND_OPT_EXT;
                n_plen = sat16({1'b0, r_fc[7:0], b} + EXT16_BIAS);
                do_len = 1'b1;
            end
            PH_DATA: begin
                kind = KIND_OPT_DATA;
                n_fc = fc_dec;
                if (fc_dec == 16'd0) begin
                    n_phase = PH_OPT_HEAD;
                end
            end
            PH_PAYLOAD: begin
                kind = KIND_PAYLOAD;
            end
            default: begin
                kind = KIND_IGNORE;
            end
        endcase

        // Delta settled: advance the option number, then pick the length path.
        if (do_delta) begin
            delta_val = sat16(delta_sum);
            n_run     = sat16({1'b0, r_run} + {1'b0, delta_val});
            n_fc      = 16'd0;
            if (n_ext == NIB_EXT8) begin
                n_phase = PH_L8;
            end else if (n_ext == NIB_EXT16) begin
                n_phase = PH_L16_HI;
            end else begin
                do_len = 1'b1;
            end
        end

        if (do_len) begin
            if (n_plen != 16'd0) begin
                n_fc    = n_plen;
                n_phase = PH_DATA;
            end else begin
                n_phase = PH_OPT_HEAD;
            end
        end

        if (i_item.end_of_datagram && (n_err == ERR_NONE)) begin
            if (r_phase <= PH_H2) begin
                n_err = ERR_SHORT;
            end else if ((n_phase == PH_TOKEN) || (n_phase == PH_DATA) ||
                         ((n_phase >= PH_D8) && (n_phase <= PH_L16_LO))) begin
                n_err = ERR_TRUNC;
            end
        end
    end

    always_comb begin
        o_result.byte_kind        = kind;
        o_result.byte_value       = b;
        o_result.option_number    = n_run;
        o_result.option_length    = n_plen;
        o_result.protocol_version = n_vt[3:2];
        o_result.message_type     = n_vt[1:0];
        o_result.token_length     = n_tl;
        o_result.code_value       = n_code;
        o_result.message_id       = n_msg_id;
        o_result.error_code       = n_err;
        o_result.message_done     = i_item.end_of_datagram;
    end

    // Parse state: cleared on reset and after the final byte of a datagram, else updated on each advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.end_of_datagram)) begin
            r_phase  <= PH_H0;
            r_fc     <= 16'd0;
            r_vt     <= 4'd0;
            r_tl     <= 4'd0;
            r_code   <= 8'd0;
            r_msg_id <= 16'd0;
            r_run    <= 16'd0;
            r_plen   <= 16'd0;
            r_ext    <= 4'd0;
            r_err    <= ERR_NONE;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_vt     <= n_vt;
            r_tl     <= n_tl;
            r_code   <= n_code;
            r_msg_id <= n_msg_id;
            r_run    <= n_run;
            r_plen   <= n_plen;
            r_ext    <= n_ext;
            r_err    <= n_err;
        end
    end

endmodule

FILE: hw/rtl/coap_message_parser.sv
// Top level of the byte-serial CoAP message parser.
//
// Input channel: one datagram byte per beat on i_in_data, with
// end_of_datagram set on the datagram's last byte. A beat is taken at a
// rising edge where i_in_valid is high and o_in_stall is low.
// Output channel: exactly one result beat per input beat, in order, on
// o_out_data; it is taken where o_out_valid is high and i_out_stall low.
// Each result classifies its byte (header, token, option head, option
// extension, option data, marker, payload, ignored) and shows the header
// fields, option number, option length and sticky error decoded so far.
// A byte accepted into the input register moves through the parse step into the result register.
// Throughput: one byte per cycle while the receiver does not stall, set by the combinational parse step
// between the input register and the result register.
// Reset (synchronous, active low) empties both registers and returns the
// parser to header byte zero. The parser also returns there by itself
// after every end-of-datagram beat.
// When the receiver stalls, the result holds; the input register still
// takes one more byte, and only then does o_in_stall rise.
module coap_message_parser
    import coap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_coap_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_coap_out o_out_data
);

    logic      r_in_valid;
    t_coap_in  r_in_data;
    logic      r_out_valid;
    t_coap_out r_out_data;

    logic      out_load;
    logic      advance;
    logic      in_take;
    t_coap_out result;

    // Result register frees up when empty or when its beat leaves.
    assign out_load   = !r_out_valid || !i_out_stall;
    // Move the held byte through the parser into the result register.
    assign advance    = r_in_valid && out_load;
    // Hold off the sender only while the input register cannot drain.
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    coap_parse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_data),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload register: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/coap_checker.sv
// Port-level checker for the CoAP message parser, bound to the top level.
module coap_checker
    import coap_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_coap_in  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_coap_out o_out_data
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // A bad token length error comes only with a nibble above eight.
    a_token_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.error_code == ERR_TOKEN)) |->
        (o_out_data.token_length > TOKEN_MAX))
        else $error("token error without oversize token length");

    // Ignored bytes only follow a bad token length.
    a_ignore_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.byte_kind == KIND_IGNORE)) |->
        (o_out_data.error_code == ERR_TOKEN))
        else $error("ignored byte without token error");

    // Token bytes need a nonzero token length.
    a_token_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.byte_kind == KIND_TOKEN)) |->
        (o_out_data.token_length != 4'd0))
        else $error("token byte with zero token length");

endmodule

bind coap_message_parser coap_checker u_coap_checker (.*);
